// File: sv/pfa_pkg.sv
// pfa_pkg: shared types, widths and the control store for the page frame allocator
// used by the sequencer and the top level; depends on nothing else

package pfa_pkg;

	localparam int FRAME_COUNT = 128;
	localparam int IDX_W       = $clog2(FRAME_COUNT);
	localparam int LINK_W      = $clog2(FRAME_COUNT + 1);
	localparam int CNT_W       = (LINK_W > 8) ? LINK_W : 8;

	localparam int COUNT_W = 8;
	localparam int CHAIN_W = 7;
	localparam int FIRST_W = 7;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(FRAME_COUNT);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef logic [2:0] step_t;

	localparam step_t STEP_IDLE   = 3'd0;
	localparam step_t STEP_CHECK  = 3'd1;
	localparam step_t STEP_READ   = 3'd2;
	localparam step_t STEP_WALK   = 3'd3;
	localparam step_t STEP_COMMIT = 3'd4;
	localparam step_t STEP_EMPTY  = 3'd5;

	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_NOSTART,
		C_EMPTY,
		C_MORE
	} cond_t;

	typedef struct packed {
		logic  ld_req;
		logic  setup;
		logic  rd_tail;
		logic  walk;
		logic  commit;
		logic  emit_empty;
		cond_t cond;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic start;
		logic early_empty;
		logic walk_more;
	} stat_t;

	function automatic logic is_null(input logic [LINK_W-1:0] v);
		return v >= NULL_LINK;
	endfunction

	// power-on link of frame i is i+1; for the last frame that equals the null code
	function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
		return LINK_W'(idx) + LINK_W'(1);
	endfunction

	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		w = '{ld_req: 1'b0, setup: 1'b0, rd_tail: 1'b0, walk: 1'b0, commit: 1'b0,
			emit_empty: 1'b0, cond: C_JUMP, target: STEP_IDLE};
		case (step)
			STEP_IDLE: begin
				w.ld_req = 1'b1;
				w.cond   = C_NOSTART;
				w.target = STEP_IDLE;
			end
			STEP_CHECK: begin
				w.setup  = 1'b1;
				w.cond   = C_EMPTY;
				w.target = STEP_EMPTY;
			end
			STEP_READ: begin
				w.rd_tail = 1'b1;
				w.cond    = C_NEXT;
			end
			STEP_WALK: begin
				w.walk   = 1'b1;
				w.cond   = C_MORE;
				w.target = STEP_WALK;
			end
			STEP_COMMIT: begin
				w.commit = 1'b1;
				w.cond   = C_JUMP;
				w.target = STEP_IDLE;
			end
			STEP_EMPTY: begin
				w.emit_empty = 1'b1;
				w.cond       = C_JUMP;
				w.target     = STEP_IDLE;
			end
			default: begin
				w.cond   = C_JUMP;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: sv/pfa_seq.sv
// pfa_seq: step counter and control store lookup for the allocator
// depends on pfa_pkg (control word, status and step codes)

module pfa_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  pfa_pkg::stat_t stat,
	output pfa_pkg::ctl_t  ctl,
	output logic           busy
);

	pfa_pkg::step_t step_q;
	pfa_pkg::step_t step_nxt;

	assign ctl  = pfa_pkg::ucode(step_q);
	assign busy = (step_q != pfa_pkg::STEP_IDLE);

	always_comb begin
		case (ctl.cond)
			pfa_pkg::C_NEXT:    step_nxt = step_q + 3'd1;
			pfa_pkg::C_JUMP:    step_nxt = ctl.target;
			pfa_pkg::C_NOSTART: step_nxt = stat.start ? step_q + 3'd1 : ctl.target;
			pfa_pkg::C_EMPTY:   step_nxt = stat.early_empty ? ctl.target : step_q + 3'd1;
			pfa_pkg::C_MORE:    step_nxt = stat.walk_more ? ctl.target : step_q + 3'd1;
			default:            step_nxt = pfa_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pfa_pkg::STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// File: sv/page_frame_free_list_allocator.sv
// page_frame_free_list_allocator: free list of page frames kept in a link memory
// depends on pfa_pkg and pfa_seq
//
// Usage: drive opcode, page_count and chain_head with start high; the request
// transfers at a rising edge where start is high and busy is low. busy stays
// high until the request is finished. Exactly one result per request appears
// on first_frame / empty_result for one cycle with done high; nothing can
// hold it off, so it must be taken in that cycle.
// Allocate (opcode 0) cuts up to page_count frames off the head of the list
// and returns the first one; free (opcode 1) walks the given chain to its
// tail and puts the chain in front of the list, always with an empty result.
// Timing: the walk reads one link per cycle from the link memory, whose read
// port is the loop. An allocate walks at most page_count frames and a free at
// most FRAME_COUNT links, also for a chain that never reaches null. Zero
// counts or an empty list go from the check straight to the empty result.
// busy drops as done rises, so the next request can transfer at the edge that
// takes the result.
// Reset: the list holds every frame in order, head at frame 0. Per-entry
// valid bits stand in for the initial links, so there is no clearing pass
// and a request can transfer in the first cycle after reset.

module page_frame_free_list_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [pfa_pkg::COUNT_W-1:0]   page_count,
	input  logic [pfa_pkg::CHAIN_W-1:0]   chain_head,
	output logic                          done,
	output logic [pfa_pkg::FIRST_W-1:0]   first_frame,
	output logic                          empty_result
);

	pfa_pkg::ctl_t  ctl;
	pfa_pkg::stat_t stat;

	// request registers
	logic                         op_q;
	logic [pfa_pkg::COUNT_W-1:0]  count_q;
	logic [pfa_pkg::CHAIN_W-1:0]  chain_q;

	// datapath
	logic [pfa_pkg::LINK_W-1:0]   head_q;
	logic [pfa_pkg::IDX_W-1:0]    tail_q;
	logic [pfa_pkg::IDX_W-1:0]    first_q;
	logic [pfa_pkg::CNT_W-1:0]    cnt_q;
	logic [pfa_pkg::CNT_W-1:0]    limit_q;

	// link memory
	logic [pfa_pkg::LINK_W-1:0]   link_mem [pfa_pkg::FRAME_COUNT];
	logic [pfa_pkg::FRAME_COUNT-1:0] vld_q;
	logic [pfa_pkg::LINK_W-1:0]   rd_data_q;
	logic                         rd_vld_q;
	logic [pfa_pkg::IDX_W-1:0]    rd_addr_q;
	logic [pfa_pkg::IDX_W-1:0]    rd_addr;
	logic                         rd_en;
	logic                         wr_en;
	logic [pfa_pkg::LINK_W-1:0]   wr_data;
	logic [pfa_pkg::LINK_W-1:0]   link;

	logic                         is_alloc;
	logic                         chain_null;
	logic                         accept;

	// result registers
	logic                         done_q;
	logic                         empty_q;
	logic [pfa_pkg::FIRST_W-1:0]  first_frame_q;

	pfa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	assign accept     = ctl.ld_req && start;
	assign is_alloc   = (op_q == pfa_pkg::OP_ALLOC);
	assign chain_null = (int'(chain_q) >= pfa_pkg::FRAME_COUNT);

	// an entry never written still holds its power-on link
	assign link = rd_vld_q ? rd_data_q : pfa_pkg::reset_link(rd_addr_q);

	assign stat.start       = start;
	assign stat.early_empty = is_alloc ?
		((count_q == '0) || pfa_pkg::is_null(head_q)) : chain_null;
	assign stat.walk_more   = (cnt_q < limit_q) && !pfa_pkg::is_null(link);

	assign rd_en   = ctl.rd_tail || (ctl.walk && stat.walk_more);
	assign rd_addr = ctl.rd_tail ? tail_q : link[pfa_pkg::IDX_W-1:0];
	assign wr_en   = ctl.commit;
	assign wr_data = is_alloc ? pfa_pkg::NULL_LINK : head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[tail_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= link_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_vld_q  <= vld_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
		if (accept) begin
			op_q    <= opcode;
			count_q <= page_count;
			chain_q <= chain_head;
		end
		if (ctl.setup) begin
			if (is_alloc) begin
				tail_q  <= pfa_pkg::IDX_W'(head_q);
				first_q <= pfa_pkg::IDX_W'(head_q);
				cnt_q   <= pfa_pkg::CNT_W'(1);
				limit_q <= pfa_pkg::CNT_W'(count_q);
			end else begin
				tail_q  <= pfa_pkg::IDX_W'(chain_q);
				first_q <= pfa_pkg::IDX_W'(chain_q);
				cnt_q   <= '0;
				limit_q <= pfa_pkg::CNT_W'(pfa_pkg::FRAME_COUNT);
			end
		end else if (ctl.walk && stat.walk_more) begin
			tail_q <= link[pfa_pkg::IDX_W-1:0];
			cnt_q  <= cnt_q + pfa_pkg::CNT_W'(1);
		end
		if (ctl.commit || ctl.emit_empty) begin
			empty_q       <= ctl.emit_empty || !is_alloc;
			first_frame_q <= (ctl.commit && is_alloc) ? pfa_pkg::FIRST_W'(first_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.commit || ctl.emit_empty;
			if (wr_en) begin
				vld_q[tail_q] <= 1'b1;
			end
			if (ctl.commit) begin
				if (is_alloc) begin
					head_q <= pfa_pkg::is_null(link) ? pfa_pkg::NULL_LINK : link;
				end else begin
					head_q <= pfa_pkg::LINK_W'(chain_q);
				end
			end
		end
	end

	assign done         = done_q;
	assign empty_result = empty_q;
	assign first_frame  = first_frame_q;

endmodule

// File: sv/pfa_chk.sv
// pfa_chk: port-level checks on the allocator's request and result timing
// depends on pfa_pkg widths; bound to page_frame_free_list_allocator below

module pfa_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        opcode,
	input logic                        done,
	input logic [pfa_pkg::FIRST_W-1:0] first_frame,
	input logic                        empty_result
);

	// a transfer always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request transfer did not raise busy");

	// a result only shows once the request is finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// the end of every request brings its result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result");

	// a free request is held busy, with no result, just after it transfers
	a_free_empty: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && opcode == pfa_pkg::OP_FREE |=> !done && busy)
		else $error("free request answered too early");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && empty_result |-> first_frame == '0)
		else $error("empty result carries a frame index");

endmodule

bind page_frame_free_list_allocator pfa_chk u_pfa_chk (.*);
